// ----- rtl/core/slga_pkg.sv -----
// Shared types and constants for the semi-Lagrangian grid advection block.
package slga_pkg;

  localparam int GRID_N_DEF = 64;
  localparam int FRAC_W     = 16;
  localparam int VAL_W      = 32;
  localparam int COORD_W    = 7;
  localparam int SCALE_W    = 31;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] SCALE_RESET = 32'd419430;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVECT  = 2'd1;
  localparam logic [1:0] OP_BOUND   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] MODE_NEG_X = 2'd1;
  localparam logic [1:0] MODE_NEG_Y = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE = 1'd1;

  typedef struct packed {
    logic [1:0]               op;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  vel_x;
    logic signed [VAL_W-1:0]  vel_y;
    logic                     bad;
  } item_t;

endpackage

// ----- rtl/core/slga_ram.sv -----
// Generic single-port RAM with registered read.
module slga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4356
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/slga_front.sv -----
// Input stage: classifies each beat and queues it for the execution stage.
module slga_front #(
  parameter int GRID_N = slga_pkg::GRID_N_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [slga_pkg::COORD_W-1:0]        in_col,
  input  logic [slga_pkg::COORD_W-1:0]        in_row,
  input  logic signed [slga_pkg::VAL_W-1:0]   in_cell_value,
  input  logic signed [slga_pkg::VAL_W-1:0]   in_vel_x,
  input  logic signed [slga_pkg::VAL_W-1:0]   in_vel_y,
  output logic                                q_valid,
  input  logic                                q_pop,
  output slga_pkg::item_t                     q_item
);

  slga_pkg::item_t items_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            in_grid, interior, bad;
  logic            push;
  slga_pkg::item_t item_w;

  always_comb begin
    in_grid  = (int'(in_col) <= GRID_N + 1) && (int'(in_row) <= GRID_N + 1);
    interior = (int'(in_col) >= 1) && (int'(in_col) <= GRID_N) &&
               (int'(in_row) >= 1) && (int'(in_row) <= GRID_N);
    unique case (in_op)
      slga_pkg::OP_ADVECT: bad = !interior;
      slga_pkg::OP_BOUND:  bad = 1'b0;
      default:             bad = !in_grid;
    endcase
    item_w.op    = in_op;
    item_w.col   = in_col;
    item_w.row   = in_row;
    item_w.value = in_cell_value;
    item_w.vel_x = in_vel_x;
    item_w.vel_y = in_vel_y;
    item_w.bad   = bad;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = items_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) items_r[wp_r] <= item_w;
  end

endmodule

// ----- rtl/core/slga_back.sv -----
// Execution stage: grid memories, trace/bilinear sequencer and boundary sweep.
module slga_back #(
  parameter int GRID_N = slga_pkg::GRID_N_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  slga_pkg::item_t                     q_item,
  input  logic [slga_pkg::SCALE_W-1:0]        step_scale,
  input  logic [slga_pkg::MODE_W-1:0]         boundary_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slga_pkg::VAL_W-1:0]   out_result_value,
  output logic                                out_status
);

  localparam int SIDE  = GRID_N + 2;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(SIDE);
  localparam int PW    = IW + 16;
  localparam int XW    = 49;
  localparam logic signed [XW-1:0] X_LO = XW'(32768);
  localparam logic signed [XW-1:0] X_HI = XW'(GRID_N * 65536 + 32768);
  localparam logic signed [37:0]   V_MAX = 38'sd2147483647;
  localparam logic signed [37:0]   V_MIN = -38'sd2147483648;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MULX  = 4'd2;
  localparam logic [3:0] ST_TRACE = 4'd3;
  localparam logic [3:0] ST_FETCH = 4'd4;
  localparam logic [3:0] ST_BL0   = 4'd5;
  localparam logic [3:0] ST_BL1   = 4'd6;
  localparam logic [3:0] ST_BL2   = 4'd7;
  localparam logic [3:0] ST_BEDGE = 4'd8;
  localparam logic [3:0] ST_BCORN = 4'd9;
  localparam logic [3:0] ST_READ  = 4'd10;
  localparam logic [3:0] ST_READW = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  localparam logic [IW-1:0] C_ONE  = IW'(1);
  localparam logic [IW-1:0] C_N    = IW'(GRID_N);
  localparam logic [IW-1:0] C_N1   = IW'(GRID_N + 1);
  localparam logic [IW-1:0] C_ZERO = IW'(0);

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] c, input logic [IW-1:0] r);
    cell_addr = AW'(c) + AW'(SIDE) * AW'(r);
  endfunction

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    if (v == 32'h8000_0000) neg_sat = 32'h7FFF_FFFF;
    else neg_sat = 32'(-$signed(v));
  endfunction

  function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] s;
    s = 33'($signed(a)) + 33'($signed(b));
    avg2 = s[32:1];
  endfunction

  logic [3:0]              state_r, state_nxt;
  slga_pkg::item_t         cur_r;
  logic [IW-1:0]           col_r, row_r;
  logic [2:0]              fk_r, fk_nxt;
  logic [IW-1:0]           bk_r, bk_nxt;
  logic [1:0]              be_r, be_nxt;
  logic [1:0]              bph_r, bph_nxt;
  logic signed [63:0]      px_r, py_r;
  logic [PW-1:0]           xq_r, yq_r;
  logic signed [49:0]      prod_r;
  logic signed [34:0]      lo_r, hi_r;
  logic signed [52:0]      bp_r;
  logic signed [37:0]      val_r;
  logic [31:0]             res_r;
  logic                    st_r;
  logic [31:0]             ca_r;
  logic                    out_valid_r;
  logic [31:0]             out_val_r;
  logic                    out_st_r;

  logic                    slot_free;
  logic signed [XW-1:0]    x_raw, y_raw, x_cl, y_cl;
  logic [IW-1:0]           i0, j0, i1, j1;
  logic [15:0]             s1, t1;
  logic [16:0]             s0, t0, tsel;
  logic signed [37:0]      vsum;
  logic [31:0]             vsat;
  logic [IW-1:0]           es_c, es_r, ed_c, ed_r;
  logic                    eneg;
  logic [IW-1:0]           ca_c, ca_rw, cb_c, cb_rw, cd_c, cd_rw;
  logic                    src_we, res_we;
  logic [AW-1:0]           src_addr, res_addr;
  logic [31:0]             src_wd, res_wd, src_rd, res_rd;

  assign slot_free = !out_valid_r || out_ready;

  // trace position and bilinear weights
  always_comb begin
    x_raw = $signed(XW'({col_r, 16'b0})) - XW'(px_r >>> 16);
    y_raw = $signed(XW'({row_r, 16'b0})) - XW'(py_r >>> 16);
    x_cl  = (x_raw < X_LO) ? X_LO : ((x_raw > X_HI) ? X_HI : x_raw);
    y_cl  = (y_raw < X_LO) ? X_LO : ((y_raw > X_HI) ? X_HI : y_raw);
    i0    = xq_r[16 +: IW];
    j0    = yq_r[16 +: IW];
    i1    = i0 + C_ONE;
    j1    = j0 + C_ONE;
    s1    = xq_r[15:0];
    t1    = yq_r[15:0];
    s0    = 17'h10000 - {1'b0, s1};
    t0    = 17'h10000 - {1'b0, t1};
    // fetch order: (i0,j0) (i0,j1) (i1,j0) (i1,j1); the RAM read is registered, so data lags the address
    tsel  = fk_r[0] ? t0 : {1'b0, t1};
    vsum  = val_r + 38'(bp_r >>> 16);
    if (vsum > V_MAX) vsat = 32'h7FFF_FFFF;
    else if (vsum < V_MIN) vsat = 32'h8000_0000;
    else vsat = vsum[31:0];
  end

  // boundary edge and corner coordinates
  always_comb begin
    case (be_r)
      2'd0: begin
        es_c = C_ONE; es_r = bk_r; ed_c = C_ZERO; ed_r = bk_r;
      end
      2'd1: begin
        es_c = C_N; es_r = bk_r; ed_c = C_N1; ed_r = bk_r;
      end
      2'd2: begin
        es_c = bk_r; es_r = C_ONE; ed_c = bk_r; ed_r = C_ZERO;
      end
      default: begin
        es_c = bk_r; es_r = C_N; ed_c = bk_r; ed_r = C_N1;
      end
    endcase
    eneg = be_r[1] ? (boundary_mode == slga_pkg::MODE_NEG_Y)
                   : (boundary_mode == slga_pkg::MODE_NEG_X);
    case (be_r)
      2'd0: begin
        cd_c = C_ZERO; cd_rw = C_ZERO; ca_c = C_ONE; ca_rw = C_ZERO;
        cb_c = C_ZERO; cb_rw = C_ONE;
      end
      2'd1: begin
        cd_c = C_ZERO; cd_rw = C_N1; ca_c = C_ONE; ca_rw = C_N1;
        cb_c = C_ZERO; cb_rw = C_N;
      end
      2'd2: begin
        cd_c = C_N1; cd_rw = C_ZERO; ca_c = C_N; ca_rw = C_ZERO;
        cb_c = C_N1; cb_rw = C_ONE;
      end
      default: begin
        cd_c = C_N1; cd_rw = C_N1; ca_c = C_N; ca_rw = C_N1;
        cb_c = C_N1; cb_rw = C_N;
      end
    endcase
  end

  // memory port control
  always_comb begin
    src_we   = 1'b0;
    src_addr = cell_addr(fk_r[1] ? i1 : i0, fk_r[0] ? j1 : j0);
    src_wd   = cur_r.value;
    res_we   = 1'b0;
    res_addr = cell_addr(col_r, row_r);
    res_wd   = vsat;
    case (state_r)
      ST_LOAD: begin
        src_we   = 1'b1;
        src_addr = cell_addr(col_r, row_r);
      end
      ST_BL2: res_we = 1'b1;
      ST_BEDGE: begin
        if (bph_r[0]) begin
          res_we   = 1'b1;
          res_addr = cell_addr(ed_c, ed_r);
          res_wd   = eneg ? neg_sat(res_rd) : res_rd;
        end else begin
          res_addr = cell_addr(es_c, es_r);
        end
      end
      ST_BCORN: begin
        case (bph_r)
          2'd0: res_addr = cell_addr(ca_c, ca_rw);
          2'd1: res_addr = cell_addr(cb_c, cb_rw);
          default: begin
            res_we   = 1'b1;
            res_addr = cell_addr(cd_c, cd_rw);
            res_wd   = avg2(ca_r, res_rd);
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fk_nxt    = fk_r;
    bk_nxt    = bk_r;
    be_nxt    = be_r;
    bph_nxt   = bph_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          fk_nxt  = 3'd0;
          bk_nxt  = C_ONE;
          be_nxt  = 2'd0;
          bph_nxt = 2'd0;
          if (q_item.bad) state_nxt = ST_DONE;
          else begin
            unique case (q_item.op)
              slga_pkg::OP_LOAD:   state_nxt = ST_LOAD;
              slga_pkg::OP_ADVECT: state_nxt = ST_MULX;
              slga_pkg::OP_BOUND:  state_nxt = ST_BEDGE;
              default:             state_nxt = ST_READ;
            endcase
          end
        end
      end
      ST_LOAD:  state_nxt = ST_DONE;
      ST_MULX:  state_nxt = ST_TRACE;
      ST_TRACE: state_nxt = ST_FETCH;
      ST_FETCH: begin
        fk_nxt = fk_r + 3'd1;
        if (fk_r == 3'd5) state_nxt = ST_BL0;
      end
      ST_BL0:   state_nxt = ST_BL1;
      ST_BL1:   state_nxt = ST_BL2;
      ST_BL2:   state_nxt = ST_DONE;
      ST_BEDGE: begin
        bph_nxt = {1'b0, ~bph_r[0]};
        if (bph_r[0]) begin
          be_nxt = be_r + 2'd1;
          if (be_r == 2'd3) begin
            bk_nxt = bk_r + C_ONE;
            if (bk_r == C_N) begin
              state_nxt = ST_BCORN;
              bph_nxt   = 2'd0;
            end
          end
        end
      end
      ST_BCORN: begin
        if (bph_r == 2'd2) begin
          bph_nxt = 2'd0;
          be_nxt  = be_r + 2'd1;
          if (be_r == 2'd3) state_nxt = ST_DONE;
        end else begin
          bph_nxt = bph_r + 2'd1;
        end
      end
      ST_READ:  state_nxt = ST_READW;
      ST_READW: state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fk_r        <= 3'd0;
      bk_r        <= C_ONE;
      be_r        <= 2'd0;
      bph_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fk_r    <= fk_nxt;
      bk_r    <= bk_nxt;
      be_r    <= be_nxt;
      bph_r   <= bph_nxt;
      if (state_r == ST_DONE && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      cur_r <= q_item;
      col_r <= IW'(q_item.col);
      row_r <= IW'(q_item.row);
      res_r <= 32'd0;
      st_r  <= q_item.bad;
    end
    if (state_r == ST_MULX) begin
      px_r <= $signed({1'b0, step_scale}) * cur_r.vel_x;
      py_r <= $signed({1'b0, step_scale}) * cur_r.vel_y;
    end
    if (state_r == ST_TRACE) begin
      xq_r <= PW'(x_cl);
      yq_r <= PW'(y_cl);
    end
    if (state_r == ST_FETCH) begin
      if (fk_r != 3'd0 && fk_r != 3'd5) prod_r <= $signed({1'b0, tsel}) * $signed(src_rd);
      case (fk_r)
        3'd2: lo_r <= 35'(prod_r >>> 16);
        3'd3: lo_r <= lo_r + 35'(prod_r >>> 16);
        3'd4: hi_r <= 35'(prod_r >>> 16);
        3'd5: hi_r <= hi_r + 35'(prod_r >>> 16);
        default: ;
      endcase
    end
    if (state_r == ST_BL0) bp_r <= $signed({1'b0, s0}) * lo_r;
    if (state_r == ST_BL1) begin
      val_r <= 38'(bp_r >>> 16);
      bp_r  <= $signed({1'b0, s1}) * hi_r;
    end
    if (state_r == ST_BL2) res_r <= vsat;
    if (state_r == ST_READW) res_r <= res_rd;
    if (state_r == ST_BCORN && bph_r == 2'd1) ca_r <= res_rd;
    if (state_r == ST_DONE && slot_free) begin
      out_val_r <= res_r;
      out_st_r  <= st_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_val_r);
  assign out_status       = out_st_r;

  slga_ram #(.WIDTH(slga_pkg::VAL_W), .DEPTH(CELLS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .addr  (src_addr),
    .wdata (src_wd),
    .rdata (src_rd)
  );

  slga_ram #(.WIDTH(slga_pkg::VAL_W), .DEPTH(CELLS)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .addr  (res_addr),
    .wdata (res_wd),
    .rdata (res_rd)
  );

endmodule

// ----- rtl/core/semi_lagrangian_grid_advection.sv -----
// Top level: configuration registers, input queue stage and execution stage.
// Work per beat: advect makes four source reads on the single-port source memory plus
// trace multiply and blend; boundary makes one read and one write of the result memory
// per border cell, and three accesses per corner.
// Up to two beats queue ahead of the execution stage; one result waits in the output register.
// Reset clears control and sets configuration to its reset values; grid contents stay undefined until written.
module semi_lagrangian_grid_advection #(
  parameter int GRID_N = slga_pkg::GRID_N_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_op,
  input  logic [slga_pkg::COORD_W-1:0]          in_col,
  input  logic [slga_pkg::COORD_W-1:0]          in_row,
  input  logic signed [slga_pkg::VAL_W-1:0]     in_cell_value,
  input  logic signed [slga_pkg::VAL_W-1:0]     in_vel_x,
  input  logic signed [slga_pkg::VAL_W-1:0]     in_vel_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [slga_pkg::VAL_W-1:0]     out_result_value,
  output logic                                  out_status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [slga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slga_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [slga_pkg::SCALE_W-1:0] step_scale_r;
  logic [slga_pkg::MODE_W-1:0]  boundary_mode_r;
  logic                         q_valid, q_pop;
  slga_pkg::item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_scale_r    <= slga_pkg::SCALE_RESET[slga_pkg::SCALE_W-1:0];
      boundary_mode_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slga_pkg::REG_STEP_SCALE: step_scale_r    <= cfg_data[slga_pkg::SCALE_W-1:0];
        default:                  boundary_mode_r <= cfg_data[slga_pkg::MODE_W-1:0];
      endcase
    end
  end

  slga_front #(.GRID_N(GRID_N)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_cell_value (in_cell_value),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  slga_back #(.GRID_N(GRID_N)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .step_scale       (step_scale_r),
    .boundary_mode    (boundary_mode_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

endmodule

// ----- dv/tb_semi_lagrangian_grid_advection.sv -----
// Self-checking testbench for the semi-Lagrangian grid advection block.
module tb_semi_lagrangian_grid_advection;
  import slga_pkg::*;

  localparam int N     = GRID_N_DEF;
  localparam int SIDE  = N + 2;
  localparam int CELLS = SIDE * SIDE;
  localparam longint ONE  = 65536;
  localparam longint HALF = 32768;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 240;
  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [31:0] cval;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } cell_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } cell_resp_t;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  class grid_scoreboard;
    logic signed [31:0] src[CELLS];
    logic signed [31:0] res[CELLS];
    longint     scale;
    logic [1:0] mode;
    cell_resp_t due_q[$];

    function new();
      scale = longint'(SCALE_RESET);
      mode  = MODE_COPY;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      if (idx == REG_STEP_SCALE) scale = longint'(d[30:0]);
      else mode = d[1:0];
    endfunction

    // Back-traced, clamped sample position in Q16.16.
    function void locate(int c, int r, logic signed [31:0] vx, logic signed [31:0] vy,
                         output longint x, output longint y);
      x = longint'(c) * ONE - ((scale * longint'(vx)) >>> 16);
      y = longint'(r) * ONE - ((scale * longint'(vy)) >>> 16);
      if (x < HALF) x = HALF;
      if (x > N * ONE + HALF) x = N * ONE + HALF;
      if (y < HALF) y = HALF;
      if (y > N * ONE + HALF) y = N * ONE + HALF;
    endfunction

    function logic signed [31:0] advect(int c, int r, logic signed [31:0] vx,
                                        logic signed [31:0] vy);
      longint x, y, s1, s0, t1, t0, lo, hi;
      int i0, j0;
      locate(c, r, vx, vy, x, y);
      i0 = int'(x >>> 16);
      j0 = int'(y >>> 16);
      s1 = x & 64'hFFFF;
      t1 = y & 64'hFFFF;
      s0 = ONE - s1;
      t0 = ONE - t1;
      lo = ((t0 * longint'(src[i0 + SIDE * j0])) >>> 16)
         + ((t1 * longint'(src[i0 + SIDE * (j0 + 1)])) >>> 16);
      hi = ((t0 * longint'(src[i0 + 1 + SIDE * j0])) >>> 16)
         + ((t1 * longint'(src[i0 + 1 + SIDE * (j0 + 1)])) >>> 16);
      return sat32(((s0 * lo) >>> 16) + ((s1 * hi) >>> 16));
    endfunction

    function logic signed [31:0] edge_val(logic signed [31:0] v, bit neg);
      return neg ? sat32(-longint'(v)) : v;
    endfunction

    function logic signed [31:0] avg2(logic signed [31:0] a, logic signed [31:0] b);
      longint s;
      s = (longint'(a) + longint'(b)) >>> 1;
      return s[31:0];
    endfunction

    function void close_box();
      bit nx, ny;
      nx = (mode == MODE_NEG_X);
      ny = (mode == MODE_NEG_Y);
      for (int k = 1; k <= N; k++) begin
        logic signed [31:0] a, b, c, d;
        a = res[1 + SIDE * k];
        b = res[N + SIDE * k];
        c = res[k + SIDE];
        d = res[k + SIDE * N];
        res[SIDE * k]           = edge_val(a, nx);
        res[N + 1 + SIDE * k]   = edge_val(b, nx);
        res[k]                  = edge_val(c, ny);
        res[k + SIDE * (N + 1)] = edge_val(d, ny);
      end
      res[0] = avg2(res[1], res[SIDE]);
      res[SIDE * (N + 1)] = avg2(res[1 + SIDE * (N + 1)], res[SIDE * N]);
      res[N + 1] = avg2(res[N], res[N + 1 + SIDE]);
      res[N + 1 + SIDE * (N + 1)] = avg2(res[N + SIDE * (N + 1)], res[N + 1 + SIDE * N]);
    endfunction

    function void note_beat(cell_req_t q);
      cell_resp_t e;
      bit in_grid, interior;
      int c, r;
      c = q.col;
      r = q.row;
      in_grid  = c <= N + 1 && r <= N + 1;
      interior = c >= 1 && c <= N && r >= 1 && r <= N;
      e.value  = '0;
      e.status = 1'b0;
      case (q.op)
        OP_LOAD:   if (in_grid) src[c + SIDE * r] = q.cval; else e.status = 1'b1;
        OP_ADVECT: begin
          if (interior) begin
            e.value = advect(c, r, q.vx, q.vy);
            res[c + SIDE * r] = e.value;
          end else e.status = 1'b1;
        end
        OP_BOUND:  close_box();
        default:   if (in_grid) e.value = res[c + SIDE * r]; else e.status = 1'b1;
      endcase
      due_q.push_back(e);
    endfunction

    function bit check_beat(logic signed [31:0] v, logic s, output string msg);
      cell_resp_t e;
      if (due_q.size() == 0) begin
        msg = $sformatf("unexpected result value=%0d status=%0d", v, s);
        return 0;
      end
      e = due_q.pop_front();
      if (v !== e.value || s !== e.status) begin
        msg = $sformatf("result mismatch: value=%0d status=%0d, predicted value=%0d status=%0d",
                        v, s, e.value, e.status);
        return 0;
      end
      return 1;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_op;
  logic [COORD_W-1:0] in_col, in_row;
  logic signed [VAL_W-1:0] in_cell_value, in_vel_x, in_vel_y;
  logic out_valid, out_ready;
  logic signed [VAL_W-1:0] out_result_value;
  logic out_status;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  semi_lagrangian_grid_advection u_dut (.*);

  grid_scoreboard sb = new();
  int  fails, n_in, n_out, phase_sent, idle_cycles;
  int  n_op[4];
  bit  calm, hold;
  bit  src_ok[CELLS];
  bit  res_ok[CELLS];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fails++;
  endtask

  // input and result monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      cell_req_t q;
      q = '{in_op, in_col, in_row, in_cell_value, in_vel_x, in_vel_y};
      sb.note_beat(q);
      n_in++;
      n_op[in_op]++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      string msg;
      n_out++;
      if (!sb.check_beat(out_result_value, out_status, msg)) report_mismatch(msg);
    end
  end

  always @(posedge clk) begin
    if (hold) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // long receiver stall while the sender keeps pushing
  initial begin
    wait (n_in >= 200);
    @(posedge clk);
    hold = 1'b1;
    repeat (400) @(posedge clk);
    hold = 1'b0;
  end

  task automatic send_item(cell_req_t q);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= q.op;
    in_col        <= q.col;
    in_row        <= q.row;
    in_cell_value <= q.cval;
    in_vel_x      <= q.vx;
    in_vel_y      <= q.vy;
    phase_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_vel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 6) return $signed($urandom_range(0, 2 ** 18)) - 32'sd131072;
    if (pick <= 8) return $urandom;
    case ($urandom_range(2))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      default: return '0;
    endcase
  endfunction

  task automatic load_cell(int c, int r, logic signed [31:0] v);
    send_item('{OP_LOAD, c[6:0], r[6:0], v, $urandom, $urandom});
    if (c <= N + 1 && r <= N + 1) src_ok[c + SIDE * r] = 1'b1;
  endtask

  task automatic need_src(int c, int r);
    if (!src_ok[c + SIDE * r]) load_cell(c, r, $urandom);
  endtask

  // advect, first loading any not yet loaded source cell the bilinear sample would touch
  task automatic advect_cell(int c, int r, logic signed [31:0] vx, logic signed [31:0] vy);
    longint x, y;
    int i0, j0;
    if (c >= 1 && c <= N && r >= 1 && r <= N) begin
      sb.locate(c, r, vx, vy, x, y);
      i0 = int'(x >>> 16);
      j0 = int'(y >>> 16);
      need_src(i0, j0);
      need_src(i0 + 1, j0);
      need_src(i0, j0 + 1);
      need_src(i0 + 1, j0 + 1);
      res_ok[c + SIDE * r] = 1'b1;
    end
    send_item('{OP_ADVECT, c[6:0], r[6:0], $urandom, vx, vy});
  endtask

  task automatic fill_edge(int c, int r);
    if (!res_ok[c + SIDE * r]) advect_cell(c, r, rand_vel(), rand_vel());
  endtask

  task automatic close_box();
    for (int k = 1; k <= N; k++) begin
      fill_edge(1, k);
      fill_edge(N, k);
      fill_edge(k, 1);
      fill_edge(k, N);
    end
    send_item('{OP_BOUND, 7'($urandom), 7'($urandom), $urandom, $urandom, $urandom});
    for (int k = 0; k <= N + 1; k++) begin
      res_ok[SIDE * k] = 1'b1;
      res_ok[N + 1 + SIDE * k] = 1'b1;
      res_ok[k] = 1'b1;
      res_ok[k + SIDE * (N + 1)] = 1'b1;
    end
  endtask

  task automatic read_cell(int c, int r);
    if (c <= N + 1 && r <= N + 1 && !res_ok[c + SIDE * r]) begin
      if (c < 1 || c > N || r < 1 || r > N) return;
      advect_cell(c, r, rand_vel(), rand_vel());
    end
    send_item('{OP_READ, c[6:0], r[6:0], $urandom, $urandom, $urandom});
  endtask

  task automatic bad_item();
    int c, r;
    c = $urandom_range(0, 127);
    r = $urandom_range(0, 127);
    case ($urandom_range(2))
      0: begin
        if (c <= N + 1) r = $urandom_range(N + 2, 127);
        load_cell(c, r, $urandom);
      end
      1: begin
        if (c <= N + 1) c = $urandom_range(N + 2, 127);
        read_cell(c, r);
      end
      default: begin
        if ($urandom_range(1)) c = 0;
        else r = $urandom_range(N + 1, 127);
        advect_cell(c, r, $urandom, $urandom);
      end
    endcase
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic random_items();
    int unsigned pick;
    while (phase_sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) advect_cell($urandom_range(1, N), $urandom_range(1, N),
                                 rand_vel(), rand_vel());
      else if (pick < 65) load_cell($urandom_range(0, N + 1), $urandom_range(0, N + 1),
                                    $urandom);
      else if (pick < 85) read_cell($urandom_range(0, N + 1), $urandom_range(0, N + 1));
      else if (pick < 95) bad_item();
      else close_box();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = OP_LOAD; in_col = '0; in_row = '0;
    in_cell_value = '0; in_vel_x = '0; in_vel_y = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and rejects at reset settings
    load_cell(0, 0, 32'sh80000000);
    load_cell(N + 1, N + 1, 32'sh7FFFFFFF);
    load_cell(127, 3, $urandom);
    load_cell(5, N + 2, $urandom);
    advect_cell(0, 9, '0, '0);
    advect_cell(7, N + 1, '0, '0);
    advect_cell(127, 127, '0, '0);
    advect_cell(2, 2, 32'sh7FFFFFFF, 32'sh80000000);
    advect_cell(N, N, 32'sh80000000, 32'sh7FFFFFFF);
    read_cell(2, 2);
    read_cell(N + 2, 1);
    read_cell(127, 127);
    random_items();
    wait_drain();

    for (int p = 1; p < 5; p++) begin
      phase_sent = 0;
      calm = (p == 3);
      case (p)
        1: begin
          write_reg(REG_STEP_SCALE, 32'd0);
          write_reg(REG_BOUND_MODE, 32'(MODE_NEG_X));
        end
        2: begin
          write_reg(REG_STEP_SCALE, 32'h7FFF_FFFF);
          write_reg(REG_BOUND_MODE, 32'(MODE_NEG_Y));
        end
        3: begin
          write_reg(REG_STEP_SCALE, 32'd65536);
          write_reg(REG_BOUND_MODE, 32'(MODE_ALT));
        end
        default: begin
          write_reg(REG_STEP_SCALE, $urandom);
          write_reg(REG_BOUND_MODE, {30'($urandom), MODE_COPY});
        end
      endcase
      if (p == 1) begin
        // zero step: sample lands on the cell itself, so the minimum value reaches
        // the left edge and its negation must saturate
        load_cell(1, 7, 32'sh80000000);
        advect_cell(1, 7, '0, '0);
        close_box();
        read_cell(0, 7);
        read_cell(0, 0);
      end
      random_items();
      wait_drain();
    end

    $display("covered %0d beats in / %0d out: load %0d, advect %0d, boundary %0d, read %0d",
             n_in, n_out, n_op[0], n_op[1], n_op[2], n_op[3]);
    $display("five register settings incl. zero and full step scale, all boundary modes");
    if (fails == 0 && sb.outstanding() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
